[design/fbp_pkg.sv]
`timescale 1ns / 1ps

package fbp_pkg;

    // Input and result items
    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } fbp_in_t;

    typedef struct packed {
        logic       forward_valid;
        logic [7:0] forward_byte;
        logic       erase_request;
        logic [1:0] status;
    } fbp_out_t;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_NAME_LENGTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_CHARS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_CHARS_HIGH = 2'd2;

    // Characters held by the configuration registers
    localparam int REG_CHARS = 16;

    // Parser phases
    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_RECORDS = 3'd1;
    localparam logic [2:0] PH_SKIP_E  = 3'd2;
    localparam logic [2:0] PH_SYNC    = 3'd3;
    localparam logic [2:0] PH_HEAD    = 3'd4;
    localparam logic [2:0] PH_BODY    = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;
    localparam logic [2:0] PH_FAILED  = 3'd7;

    // Status codes
    localparam logic [1:0] STATUS_PARSING = 2'd0;
    localparam logic [1:0] STATUS_DONE    = 2'd1;
    localparam logic [1:0] STATUS_FAILED  = 2'd2;

    // File format constants
    localparam logic [8:0]  MAGIC_LEN     = 9'd13;
    localparam logic [8:0]  E_SKIP_LEN    = 9'd5;
    localparam logic [7:0]  CH_B          = 8'h62;
    localparam logic [7:0]  CH_E          = 8'h65;
    localparam logic [31:0] SYNC_WORD     = 32'hAA995566;
    localparam logic [2:0]  PKT_TYPE1     = 3'd1;
    localparam logic [2:0]  PKT_TYPE2     = 3'd2;
    localparam logic [7:0]  CMD_REG_ADDR  = 8'h04;
    localparam logic [4:0]  DESYNC_OPCODE = 5'h0d;

    // Expected magic byte at a given position of the file
    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] val;
        unique case (idx)
            4'd0:    val = 8'h00;
            4'd1:    val = 8'h09;
            4'd2:    val = 8'h0f;
            4'd3:    val = 8'hf0;
            4'd4:    val = 8'h0f;
            4'd5:    val = 8'hf0;
            4'd6:    val = 8'h0f;
            4'd7:    val = 8'hf0;
            4'd8:    val = 8'h0f;
            4'd9:    val = 8'hf0;
            4'd10:   val = 8'h00;
            4'd11:   val = 8'h00;
            4'd12:   val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

[design/fbp_cfg.sv]
`timescale 1ns / 1ps

module fbp_cfg
    import fbp_pkg::*;
#(
    parameter int NAME_LIM = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    output logic [4:0]                     name_lim,
    output logic [NAME_LIM-1:0][7:0]       name_bytes,
    output logic [NAME_LIM-1:0]            char_nz
);

    logic [4:0]                name_length_reg;
    logic [NAME_LIM-1:0][7:0]  name_reg;

    // Hold the name length as written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_length_reg <= '0;
        end
        else if (cfg_we && cfg_index == REG_NAME_LENGTH)
        begin
            name_length_reg <= cfg_data[4:0];
        end
    end

    // Hold only the characters the compare can ever reach
    for (genvar g = 0; g < NAME_LIM; g++)
    begin : g_char
        if (g < 8)
        begin : g_low
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    name_reg[g] <= '0;
                end
                else if (cfg_we && cfg_index == REG_NAME_CHARS_LOW)
                begin
                    name_reg[g] <= cfg_data[8*g +: 8];
                end
            end
        end
        else
        begin : g_high
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    name_reg[g] <= '0;
                end
                else if (cfg_we && cfg_index == REG_NAME_CHARS_HIGH)
                begin
                    name_reg[g] <= cfg_data[8*(g-8) +: 8];
                end
            end
        end

        // Flag positions that hold a live, non-zero expected character
        assign char_nz[g] = (5'(g) < name_lim) && (name_reg[g] != 8'h00);
    end

    // Clamp the length to the stored characters
    assign name_lim   = (name_length_reg > 5'(NAME_LIM)) ? 5'(NAME_LIM) : name_length_reg;
    assign name_bytes = name_reg;

endmodule

[design/fbp_core.sv]
`timescale 1ns / 1ps

module fbp_core
    import fbp_pkg::*;
#(
    parameter int NAME_LIM = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  fbp_in_t                    item,
    input  logic [4:0]                 name_lim,
    input  logic [NAME_LIM-1:0][7:0]   name_bytes,
    input  logic [NAME_LIM-1:0]        char_nz,
    output fbp_out_t                   result
);

    localparam int IW = (NAME_LIM > 1) ? $clog2(NAME_LIM) : 1;

    logic [2:0]  phase_reg,        phase_next;
    logic [8:0]  sc_reg,           sc_next;
    logic [31:0] header_shift_reg, header_shift_next;
    logic        mismatch_reg,     mismatch_next;
    logic [7:0]  kind_reg,         kind_next;
    logic [7:0]  length_reg,       length_next;
    logic        name_equal_reg,   name_equal_next;
    logic [31:0] sync_window_reg,  sync_window_next;
    logic        cmd_watch_reg,    cmd_watch_next;
    logic [26:0] words_left_reg,   words_left_next;
    logic [1:0]  biw_reg,          biw_next;

    logic [2:0]  c_phase;
    logic [8:0]  c_sc;
    logic [31:0] c_hs;
    logic        c_mm;
    logic [7:0]  c_kind;
    logic [7:0]  c_len;
    logic        c_eq;
    logic [31:0] c_sync;
    logic        c_cw;
    logic [26:0] c_wl;
    logic [1:0]  c_biw;

    logic [7:0]  b;
    logic [8:0]  idx_wide;
    logic [7:0]  idx;
    logic [7:0]  exp_char;
    logic        nz_len;
    logic        fwd;
    logic        erase;

    assign b = item.data_byte;

    // Start from a clean parser when the item opens a new file
    always_comb
    begin
        if (item.file_start)
        begin
            c_phase = PH_MAGIC;
            c_sc    = '0;
            c_hs    = '0;
            c_mm    = 1'b0;
            c_kind  = '0;
            c_len   = '0;
            c_eq    = 1'b1;
            c_sync  = '0;
            c_cw    = 1'b0;
            c_wl    = '0;
            c_biw   = '0;
        end
        else
        begin
            c_phase = phase_reg;
            c_sc    = sc_reg;
            c_hs    = header_shift_reg;
            c_mm    = mismatch_reg;
            c_kind  = kind_reg;
            c_len   = length_reg;
            c_eq    = name_equal_reg;
            c_sync  = sync_window_reg;
            c_cw    = cmd_watch_reg;
            c_wl    = words_left_reg;
            c_biw   = biw_reg;
        end
    end

    // Look up the expected name character for this payload byte
    assign idx_wide = c_sc - 9'd3;
    assign idx      = idx_wide[7:0];
    assign exp_char = ({3'b000, name_lim} > idx) ? name_bytes[idx[IW-1:0]] : 8'h00;
    assign nz_len   = (c_len < 8'(NAME_LIM)) ? char_nz[c_len[IW-1:0]] : 1'b0;

    // Advance the parser by one byte
    always_comb
    begin
        phase_next        = c_phase;
        sc_next           = c_sc;
        header_shift_next = c_hs;
        mismatch_next     = c_mm;
        kind_next         = c_kind;
        length_next       = c_len;
        name_equal_next   = c_eq;
        sync_window_next  = c_sync;
        cmd_watch_next    = c_cw;
        words_left_next   = c_wl;
        biw_next          = c_biw;
        fwd               = 1'b0;
        erase             = 1'b0;

        unique case (c_phase)
            PH_MAGIC:
            begin
                if (b != magic_byte(c_sc[3:0]))
                begin
                    mismatch_next = 1'b1;
                end
                sc_next = c_sc + 9'd1;
                if (sc_next >= MAGIC_LEN)
                begin
                    phase_next = mismatch_next ? PH_FAILED : PH_RECORDS;
                    sc_next    = '0;
                end
            end
            PH_RECORDS:
            begin
                if (c_sc == 9'd0)
                begin
                    kind_next       = b;
                    name_equal_next = 1'b1;
                    sc_next         = 9'd1;
                    if (b == CH_E)
                    begin
                        phase_next = PH_SKIP_E;
                    end
                end
                else if (c_sc == 9'd1)
                begin
                    sc_next = 9'd2;
                end
                else if (c_sc == 9'd2)
                begin
                    length_next = b;
                    sc_next     = 9'd3;
                    // Empty record closes on its length byte
                    if (b == 8'h00)
                    begin
                        if (kind_next == CH_B && (!name_equal_next || char_nz[0]))
                        begin
                            phase_next = PH_FAILED;
                        end
                        sc_next = '0;
                    end
                end
                else
                begin
                    if (c_kind == CH_B && c_eq)
                    begin
                        if (b != exp_char)
                        begin
                            name_equal_next = 1'b0;
                        end
                        else if (b == 8'h00)
                        begin
                            kind_next = 8'h00;
                        end
                    end
                    sc_next = c_sc + 9'd1;
                    if (({1'b0, idx} + 9'd1) >= {1'b0, c_len})
                    begin
                        if (kind_next == CH_B && (!name_equal_next || nz_len))
                        begin
                            phase_next = PH_FAILED;
                        end
                        sc_next = '0;
                    end
                end
            end
            PH_SKIP_E:
            begin
                sc_next = c_sc + 9'd1;
                if (sc_next >= E_SKIP_LEN)
                begin
                    erase            = 1'b1;
                    phase_next       = PH_SYNC;
                    sc_next          = '0;
                    sync_window_next = '0;
                end
            end
            PH_SYNC:
            begin
                fwd              = 1'b1;
                sync_window_next = {c_sync[23:0], b};
                if (sync_window_next == SYNC_WORD)
                begin
                    phase_next = PH_HEAD;
                    biw_next   = '0;
                end
            end
            PH_HEAD:
            begin
                if (c_biw == 2'd0 && b[7:5] != PKT_TYPE1 && b[7:5] != PKT_TYPE2)
                begin
                    phase_next = PH_FAILED;
                end
                else
                begin
                    fwd               = 1'b1;
                    header_shift_next = {c_hs[23:0], b};
                    if (c_biw == 2'd3)
                    begin
                        if (header_shift_next[31:29] == PKT_TYPE1)
                        begin
                            cmd_watch_next  = (header_shift_next[28:27] != 2'd0)
                                           && (header_shift_next[9:0] == 10'd1)
                                           && (header_shift_next[20:13] == CMD_REG_ADDR);
                            words_left_next = {17'd0, header_shift_next[9:0]};
                        end
                        else
                        begin
                            cmd_watch_next  = 1'b0;
                            words_left_next = header_shift_next[26:0];
                        end
                        if (words_left_next != 27'd0)
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                    biw_next = c_biw + 2'd1;
                end
            end
            PH_BODY:
            begin
                fwd = 1'b1;
                if (c_biw == 2'd3)
                begin
                    words_left_next = c_wl - 27'd1;
                    if (c_cw && b[4:0] == DESYNC_OPCODE)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (words_left_next == 27'd0)
                    begin
                        phase_next = PH_HEAD;
                    end
                end
                biw_next = c_biw + 2'd1;
            end
            PH_DONE, PH_FAILED:
            begin
                // Absorb bytes until the next file
            end
        endcase
    end

    // Form the result item
    always_comb
    begin
        result.forward_valid = fwd;
        result.forward_byte  = fwd ? b : 8'h00;
        result.erase_request = erase;
        if (phase_next == PH_DONE)
        begin
            result.status = STATUS_DONE;
        end
        else if (phase_next == PH_FAILED)
        begin
            result.status = STATUS_FAILED;
        end
        else
        begin
            result.status = STATUS_PARSING;
        end
    end

    // Commit the parser state when the item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_MAGIC;
            sc_reg           <= '0;
            header_shift_reg <= '0;
            mismatch_reg     <= 1'b0;
            kind_reg         <= '0;
            length_reg       <= '0;
            name_equal_reg   <= 1'b1;
            sync_window_reg  <= '0;
            cmd_watch_reg    <= 1'b0;
            words_left_reg   <= '0;
            biw_reg          <= '0;
        end
        else if (take)
        begin
            phase_reg        <= phase_next;
            sc_reg           <= sc_next;
            header_shift_reg <= header_shift_next;
            mismatch_reg     <= mismatch_next;
            kind_reg         <= kind_next;
            length_reg       <= length_next;
            name_equal_reg   <= name_equal_next;
            sync_window_reg  <= sync_window_next;
            cmd_watch_reg    <= cmd_watch_next;
            words_left_reg   <= words_left_next;
            biw_reg          <= biw_next;
        end
    end

endmodule

[design/fpga_bitstream_file_parser.sv]
`timescale 1ns / 1ps
// Throughput: one byte per cycle unless out_stall holds a full result register;
// each byte passes through an input register, the combinational parser logic and
// a result register, with no loop inside the parser step.
// Reset: rst_n clears the pipeline, the parser state and the name registers at once;
// file_start on an item clears the parser state (not the name registers) before it.

module fpga_bitstream_file_parser
    import fbp_pkg::*;
#(
    parameter int NAME_CHARS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  fbp_in_t                in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output fbp_out_t               out_item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int NAME_LIM = (NAME_CHARS < REG_CHARS) ? NAME_CHARS : REG_CHARS;

    logic                     s1_valid_reg;
    fbp_in_t                  s1_item_reg;
    logic                     out_valid_reg;
    fbp_out_t                 out_item_reg;
    logic                     advance;
    logic                     take;
    fbp_out_t                 result;
    logic [4:0]               name_lim;
    logic [NAME_LIM-1:0][7:0] name_bytes;
    logic [NAME_LIM-1:0]      char_nz;

    fbp_cfg #(
        .NAME_LIM (NAME_LIM)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .name_lim   (name_lim),
        .name_bytes (name_bytes),
        .char_nz    (char_nz)
    );

    fbp_core #(
        .NAME_LIM (NAME_LIM)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .item       (s1_item_reg),
        .name_lim   (name_lim),
        .name_bytes (name_bytes),
        .char_nz    (char_nz),
        .result     (result)
    );

    // Move the pipeline whenever the result register is free or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign take     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_item_reg <= in_item;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled while the result register could drain");

    a_erase_not_forwarded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.erase_request) |->
            (!out_item.forward_valid && out_item.status == STATUS_PARSING))
        else $error("erase request on a forwarded or finished item");

    a_byte_zero_when_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.forward_valid) |-> (out_item.forward_byte == 8'h00))
        else $error("byte present on a dropped item");

    a_taken_item_lands: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("taken item did not reach the result register");

endmodule
